[src/stb_pkg.sv]
// shared types, constants and character-class helpers for the source byte tokenizer
`default_nettype none

package stb_pkg;

  typedef enum logic [3:0] {
    TK_IDENT    = 4'd0,
    TK_INT      = 4'd1,
    TK_RETURN   = 4'd2,
    TK_FUNC     = 4'd3,
    TK_EXTERN   = 4'd4,
    TK_I32      = 4'd5,
    TK_U8       = 4'd6,
    TK_PUNCT    = 4'd7,
    TK_STR_BYTE = 4'd8,
    TK_STR_END  = 4'd9,
    TK_ERROR    = 4'd10,
    TK_END_OK   = 4'd11,
    TK_END_FAIL = 4'd12
  } tok_kind_t;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_IDENT   = 7'b0000010,
    MODE_INT     = 7'b0000100,
    MODE_DASH    = 7'b0001000,
    MODE_COMMENT = 7'b0010000,
    MODE_STRING  = 7'b0100000,
    MODE_ESC     = 7'b1000000
  } lex_mode_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  tbyte;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } lex_out_t;

  localparam int NUM_KW = 5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  localparam logic [47:0] KW_TEXT [NUM_KW] = '{
    "return", {"func", 16'h0}, "extern", {"i32", 24'h0}, {"u8", 32'h0}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd4, 3'd6, 3'd3, 3'd2};
  localparam tok_kind_t KW_KIND [NUM_KW] = '{TK_RETURN, TK_FUNC, TK_EXTERN, TK_I32, TK_U8};

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {["0":"9"]});
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c inside {";", ":", ",", "{", "}", "(", ")", "*", "-", ">", "&", "="});
  endfunction

  // narrow the keyword candidates by the character at position pos
  function automatic logic [NUM_KW-1:0] kw_next(input logic [NUM_KW-1:0] m,
                                                input logic pos_ok,
                                                input logic [2:0] pos,
                                                input logic [7:0] c);
    logic [NUM_KW-1:0] r;
    r = m;
    for (int i = 0; i < NUM_KW; i++) begin
      if (!(pos_ok && pos < KW_LEN[i] && KW_TEXT[i][8*(5-int'(pos)) +: 8] == c)) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic tok_kind_t word_kind(input logic [NUM_KW-1:0] m,
                                          input logic len_ok,
                                          input logic [2:0] len);
    tok_kind_t k;
    k = TK_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (m[i] && len_ok && len == KW_LEN[i]) begin
        k = KW_KIND[i];
      end
    end
    return k;
  endfunction

  // bit 8 set marks a bad escape
  function automatic logic [8:0] esc_decode(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      "n":     r = 9'h00A;
      "t":     r = 9'h009;
      "r":     r = 9'h00D;
      "b":     r = 9'h008;
      "f":     r = 9'h00C;
      "v":     r = 9'h00B;
      "0":     r = 9'h000;
      default: r = 9'h100;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/stb_lexer.sv]
// lexer state registers and the per-byte next-state and token event logic
`default_nettype none

module stb_lexer import stb_pkg::*; #(
  parameter int POS_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] src_byte,
  output lex_out_t        lex_out
);

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  lex_mode_t         mode, mode_next;
  logic [POS_BITS-1:0] cur_line, cur_line_next;
  logic [POS_BITS-1:0] cur_column, cur_column_next;
  logic [POS_BITS-1:0] start_column, start_column_next;
  logic [POS_BITS-1:0] run_length, run_length_next;
  logic [NUM_KW-1:0] keyword_match, keyword_match_next;
  logic              error_seen, error_seen_next;

  logic        go_idle, ended, rl_small;
  logic [2:0]  rl_pos;
  logic [8:0]  esc;
  logic        mode_ev, idle_ev, end_ev;
  result_t     mode_res, idle_res, end_res;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic logic [15:0] out16(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic result_t mk(input tok_kind_t k, input logic [7:0] b,
                                 input logic [POS_BITS-1:0] ln,
                                 input logic [POS_BITS-1:0] col,
                                 input logic [POS_BITS-1:0] len);
    result_t r;
    r.kind   = k;
    r.tbyte  = b;
    r.line   = out16(ln);
    r.column = out16(col);
    r.length = out16(len);
    r.last   = 1'b0;
    return r;
  endfunction

  assign rl_small = (run_length < POS_BITS'(8));
  assign rl_pos   = run_length[2:0];
  assign esc      = esc_decode(src_byte);

  always_comb begin
    mode_next          = mode;
    cur_line_next      = cur_line;
    cur_column_next    = cur_column;
    start_column_next  = start_column;
    run_length_next    = run_length;
    keyword_match_next = keyword_match;
    error_seen_next    = error_seen;
    go_idle  = 1'b0;
    ended    = 1'b0;
    mode_ev  = 1'b0;
    idle_ev  = 1'b0;
    end_ev   = 1'b0;
    mode_res = '0;
    idle_res = '0;
    end_res  = '0;

    case (mode)
      MODE_IDENT: begin
        if (is_alpha(src_byte) || is_digit(src_byte) || src_byte == CH_USCORE) begin
          keyword_match_next = kw_next(keyword_match, rl_small, rl_pos, src_byte);
          run_length_next    = sat_inc(run_length);
        end else begin
          mode_ev  = 1'b1;
          mode_res = mk(word_kind(keyword_match, rl_small, rl_pos), 8'h00, cur_line,
                        start_column, run_length);
          go_idle  = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_digit(src_byte)) begin
          run_length_next = sat_inc(run_length);
        end else begin
          mode_ev  = 1'b1;
          mode_res = mk(TK_INT, 8'h00, cur_line, start_column, run_length);
          go_idle  = 1'b1;
        end
      end
      MODE_DASH: begin
        if (src_byte == CH_DASH) begin
          mode_next = MODE_COMMENT;
        end else if (is_digit(src_byte)) begin
          mode_next       = MODE_INT;
          run_length_next = POS_BITS'(2);
        end else begin
          mode_ev  = 1'b1;
          mode_res = mk(TK_PUNCT, CH_DASH, cur_line, start_column, '0);
          go_idle  = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (src_byte == CH_NUL) begin
          ended = 1'b1;
        end else if (src_byte == CH_LF) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (src_byte == CH_NUL) begin
          mode_ev         = 1'b1;
          mode_res        = mk(TK_ERROR, 8'h00, cur_line, start_column, '0);
          error_seen_next = 1'b1;
          ended           = 1'b1;
        end else if (src_byte == CH_QUOTE) begin
          mode_ev   = 1'b1;
          mode_res  = mk(TK_STR_END, 8'h00, cur_line, start_column, run_length);
          mode_next = MODE_IDLE;
        end else if (src_byte == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          run_length_next = sat_inc(run_length);
          mode_ev         = 1'b1;
          mode_res        = mk(TK_STR_BYTE, src_byte, cur_line, start_column,
                               sat_inc(run_length));
        end
      end
      MODE_ESC: begin
        mode_ev = 1'b1;
        if (src_byte == CH_NUL) begin
          mode_res        = mk(TK_ERROR, 8'h00, cur_line, start_column, '0);
          error_seen_next = 1'b1;
          ended           = 1'b1;
        end else begin
          mode_next = MODE_STRING;
          if (esc[8]) begin
            mode_res        = mk(TK_ERROR, src_byte, cur_line, start_column, '0);
            error_seen_next = 1'b1;
          end else begin
            run_length_next = sat_inc(run_length);
            mode_res        = mk(TK_STR_BYTE, esc[7:0], cur_line, start_column,
                                 sat_inc(run_length));
          end
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    if (go_idle) begin
      mode_next = MODE_IDLE;
      if (src_byte == CH_NUL) begin
        ended = 1'b1;
      end else if (is_space(src_byte)) begin
        mode_next = MODE_IDLE;
      end else if (src_byte == CH_DASH) begin
        mode_next         = MODE_DASH;
        start_column_next = cur_column;
      end else if (is_alpha(src_byte) || src_byte == CH_USCORE) begin
        mode_next          = MODE_IDENT;
        start_column_next  = cur_column;
        keyword_match_next = kw_next('1, 1'b1, 3'd0, src_byte);
        run_length_next    = POS_ONE;
      end else if (is_digit(src_byte)) begin
        mode_next         = MODE_INT;
        start_column_next = cur_column;
        run_length_next   = POS_ONE;
      end else if (src_byte == CH_QUOTE) begin
        mode_next         = MODE_STRING;
        start_column_next = sat_inc(cur_column);
        run_length_next   = '0;
      end else if (is_punct(src_byte)) begin
        idle_ev  = 1'b1;
        idle_res = mk(TK_PUNCT, src_byte, cur_line, cur_column, '0);
      end else begin
        idle_ev         = 1'b1;
        idle_res        = mk(TK_ERROR, src_byte, cur_line, cur_column, '0);
        error_seen_next = 1'b1;
      end
    end

    if (ended) begin
      end_ev  = 1'b1;
      end_res = mk(error_seen_next ? TK_END_FAIL : TK_END_OK, 8'h00, cur_line, cur_column,
                   '0);
      mode_next          = MODE_IDLE;
      cur_line_next      = POS_ONE;
      cur_column_next    = POS_ONE;
      start_column_next  = POS_ONE;
      run_length_next    = '0;
      keyword_match_next = '1;
      error_seen_next    = 1'b0;
    end else if (src_byte == CH_LF) begin
      cur_line_next   = sat_inc(cur_line);
      cur_column_next = POS_ONE;
    end else begin
      cur_column_next = sat_inc(cur_column);
    end

    // pack the events in order: pending token, idle handling, end of source
    lex_out.count = 2'(mode_ev) + 2'(idle_ev) + 2'(end_ev);
    lex_out.r1    = '0;
    if (mode_ev) begin
      lex_out.r0 = mode_res;
      lex_out.r1 = idle_ev ? idle_res : end_res;
    end else if (idle_ev) begin
      lex_out.r0 = idle_res;
      lex_out.r1 = end_res;
    end else begin
      lex_out.r0 = end_res;
    end
    lex_out.r0.last = (lex_out.count == 2'd1);
    lex_out.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      cur_line      <= POS_ONE;
      cur_column    <= POS_ONE;
      start_column  <= POS_ONE;
      run_length    <= '0;
      keyword_match <= '1;
      error_seen    <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      cur_line      <= cur_line_next;
      cur_column    <= cur_column_next;
      start_column  <= start_column_next;
      run_length    <= run_length_next;
      keyword_match <= keyword_match_next;
      error_seen    <= error_seen_next;
    end
  end

endmodule

`default_nettype wire

[src/source_byte_tokenizer_core.sv]
// Streaming source tokenizer: takes one source byte per word on the src channel and
// delivers token events on the token channel. A byte is taken every cycle while the
// token channel drains; a byte that closes a pending token and is also punctuation, a
// bad byte or the zero end byte gives two words, and the next byte waits while the
// second word goes out through the two-entry result register. Line, column and length
// counters are POS_BITS wide and saturate; the reported fields saturate at 65535.
// A zero byte ends the source with an end-ok or end-failed word and clears all state.
`default_nettype none

module source_byte_tokenizer_core import stb_pkg::*; #(
  parameter int POS_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        src_valid,
  output      logic        src_stall,
  input  wire logic [7:0]  src_byte,
  output      logic        token_valid,
  input  wire logic        token_stall,
  output      logic [3:0]  token_kind,
  output      logic [7:0]  token_byte,
  output      logic [15:0] token_line,
  output      logic [15:0] token_column,
  output      logic [15:0] token_length,
  output      logic        last_of_run
);

  lex_out_t   lex_out;
  result_t    q0, q1;
  logic [1:0] cnt;
  logic       accept, pop;

  assign token_valid = (cnt != 2'd0);
  assign pop         = token_valid && !token_stall;
  assign src_stall   = !((cnt == 2'd0) || (cnt == 2'd1 && !token_stall));
  assign accept      = src_valid && !src_stall;

  stb_lexer #(
    .POS_BITS(POS_BITS)
  ) u_lexer (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .src_byte(src_byte),
    .lex_out (lex_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      cnt <= lex_out.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q0 <= lex_out.r0;
      q1 <= lex_out.r1;
    end else if (pop) begin
      q0 <= q1;
    end
  end

  assign token_kind   = q0.kind;
  assign token_byte   = q0.tbyte;
  assign token_line   = q0.line;
  assign token_column = q0.column;
  assign token_length = q0.length;
  assign last_of_run  = q0.last;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("result count out of range");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> (src_stall && !q0.last && q1.last))
    else $error("two queued words with bad stall or last flags");

  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    (accept && lex_out.count == 2'd0) |=> !token_valid)
    else $error("word shown for a byte that gave none");

  a_second_word: assert property (@(posedge clk) disable iff (rst)
    (pop && cnt == 2'd2) |=> (token_valid && last_of_run))
    else $error("second word lost after first was taken");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !token_valid)
    else $error("result queue not empty after reset");

endmodule

`default_nettype wire

[bench/testbench.sv]
// self-checking bench for source_byte_tokenizer_core: directed table and random text
`timescale 1ns / 1ps

module testbench;
  import stb_pkg::*;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    result_t    want;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_stall;
  logic [7:0]  src_byte = 8'h00;
  logic        token_valid;
  logic        token_stall = 1'b0;
  logic [3:0]  token_kind;
  logic [7:0]  token_byte;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [15:0] token_length;
  logic        last_of_run;

  int sender_idle = 0;
  int stall_pct = 0;
  int mismatches = 0;

  result_t    expected_tokens [$];
  result_t    byte_tokens [$];
  logic [7:0] src_text [$];

  // tokenizer state as seen by the bench
  lex_mode_t   mode;
  logic [15:0] line_no;
  logic [15:0] col_no;
  logic [15:0] tok_col;
  logic [15:0] tok_len;
  logic [4:0]  kw_hits;
  logic        had_error;

  string      kw_words [5] = '{"return", "func", "extern", "i32", "u8"};
  tok_kind_t  kw_kinds [5] = '{TK_RETURN, TK_FUNC, TK_EXTERN, TK_I32, TK_U8};
  string      sym_chars = ";:,{}()*->&=";
  string      esc_chars = "ntrbfv0";
  string      word_chars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

  dir_row_t dir_rows [22] = '{
    '{";",       1'b1, '{TK_PUNCT,    ";",   16'd1, 16'd1, 16'd0, 1'b1}},
    '{8'hFF,     1'b1, '{TK_ERROR,    8'hFF, 16'd1, 16'd2, 16'd0, 1'b1}},
    '{CH_NUL,    1'b1, '{TK_END_FAIL, 8'h00, 16'd1, 16'd3, 16'd0, 1'b1}},
    '{CH_NUL,    1'b1, '{TK_END_OK,   8'h00, 16'd1, 16'd1, 16'd0, 1'b1}},
    '{"u",       1'b0, '0},
    '{"8",       1'b0, '0},
    '{CH_DASH,   1'b0, '0},
    '{"5",       1'b0, '0},
    '{CH_QUOTE,  1'b0, '0},
    '{"a",       1'b0, '0},
    '{CH_BSLASH, 1'b0, '0},
    '{"q",       1'b0, '0},
    '{CH_BSLASH, 1'b0, '0},
    '{"n",       1'b0, '0},
    '{CH_NUL,    1'b0, '0},
    '{CH_DASH,   1'b0, '0},
    '{"x",       1'b0, '0},
    '{CH_DASH,   1'b0, '0},
    '{CH_DASH,   1'b0, '0},
    '{"z",       1'b0, '0},
    '{CH_LF,     1'b0, '0},
    '{CH_NUL,    1'b0, '0}
  };

  source_byte_tokenizer_core dut (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .src_byte     (src_byte),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_kind   (token_kind),
    .token_byte   (token_byte),
    .token_line   (token_line),
    .token_column (token_column),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [15:0] sat_up(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_sym(input logic [7:0] c);
    for (int i = 0; i < sym_chars.len(); i++) begin
      if (sym_chars[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_lexer();
    mode = MODE_IDLE;
    line_no = 16'd1;
    col_no = 16'd1;
    tok_col = 16'd1;
    tok_len = 16'd0;
    kw_hits = 5'h1F;
    had_error = 1'b0;
  endfunction

  function automatic void put(tok_kind_t k, logic [7:0] b, logic [15:0] col,
                              logic [15:0] len);
    result_t r;
    r.kind = k;
    r.tbyte = b;
    r.line = line_no;
    r.column = col;
    r.length = len;
    r.last = 1'b0;
    byte_tokens.push_back(r);
  endfunction

  function automatic void flag_error(logic [7:0] b, logic [15:0] col);
    put(TK_ERROR, b, col, 16'd0);
    had_error = 1'b1;
  endfunction

  function automatic void kw_narrow(logic [7:0] c);
    for (int i = 0; i < 5; i++) begin
      if (tok_len >= kw_words[i].len() || kw_words[i][tok_len] != c) kw_hits[i] = 1'b0;
    end
  endfunction

  function automatic tok_kind_t word_kind();
    tok_kind_t k;
    k = TK_IDENT;
    for (int i = 0; i < 5; i++) begin
      if (kw_hits[i] && tok_len == kw_words[i].len()) k = kw_kinds[i];
    end
    return k;
  endfunction

  // works out the token words caused by one source byte
  function automatic void lex_byte(input logic [7:0] c);
    bit restart;
    bit done;
    logic [8:0] dec;
    byte_tokens = {};
    restart = 1'b0;
    done = 1'b0;
    case (mode)
      MODE_IDENT: begin
        if (is_letter(c) || is_num(c) || c == CH_USCORE) begin
          kw_narrow(c);
          tok_len = sat_up(tok_len);
        end else begin
          put(word_kind(), 8'h00, tok_col, tok_len);
          restart = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_num(c)) begin
          tok_len = sat_up(tok_len);
        end else begin
          put(TK_INT, 8'h00, tok_col, tok_len);
          restart = 1'b1;
        end
      end
      MODE_DASH: begin
        if (c == CH_DASH) begin
          mode = MODE_COMMENT;
        end else if (is_num(c)) begin
          mode = MODE_INT;
          tok_len = 16'd2;
        end else begin
          put(TK_PUNCT, CH_DASH, tok_col, 16'd0);
          restart = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NUL) done = 1'b1;
        else if (c == CH_LF) mode = MODE_IDLE;
      end
      MODE_STRING: begin
        if (c == CH_NUL) begin
          flag_error(CH_NUL, tok_col);
          done = 1'b1;
        end else if (c == CH_QUOTE) begin
          put(TK_STR_END, 8'h00, tok_col, tok_len);
          mode = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
          mode = MODE_ESC;
        end else begin
          tok_len = sat_up(tok_len);
          put(TK_STR_BYTE, c, tok_col, tok_len);
        end
      end
      MODE_ESC: begin
        if (c == CH_NUL) begin
          flag_error(CH_NUL, tok_col);
          done = 1'b1;
        end else begin
          mode = MODE_STRING;
          case (c)
            "n":     dec = 9'h00A;
            "t":     dec = 9'h009;
            "r":     dec = 9'h00D;
            "b":     dec = 9'h008;
            "f":     dec = 9'h00C;
            "v":     dec = 9'h00B;
            "0":     dec = 9'h000;
            default: dec = 9'h100;
          endcase
          if (dec[8]) begin
            flag_error(c, tok_col);
          end else begin
            tok_len = sat_up(tok_len);
            put(TK_STR_BYTE, dec[7:0], tok_col, tok_len);
          end
        end
      end
      default: restart = 1'b1;
    endcase

    if (restart) begin
      mode = MODE_IDLE;
      if (c == CH_NUL) begin
        done = 1'b1;
      end else if (is_blank(c)) begin
      end else if (c == CH_DASH) begin
        mode = MODE_DASH;
        tok_col = col_no;
      end else if (is_letter(c) || c == CH_USCORE) begin
        mode = MODE_IDENT;
        tok_col = col_no;
        kw_hits = 5'h1F;
        tok_len = 16'd0;
        kw_narrow(c);
        tok_len = 16'd1;
      end else if (is_num(c)) begin
        mode = MODE_INT;
        tok_col = col_no;
        tok_len = 16'd1;
      end else if (c == CH_QUOTE) begin
        mode = MODE_STRING;
        tok_col = sat_up(col_no);
        tok_len = 16'd0;
      end else if (is_sym(c)) begin
        put(TK_PUNCT, c, col_no, 16'd0);
      end else begin
        flag_error(c, col_no);
      end
    end

    if (done) begin
      put(had_error ? TK_END_FAIL : TK_END_OK, 8'h00, col_no, 16'd0);
      clear_lexer();
    end else if (c == CH_LF) begin
      line_no = sat_up(line_no);
      col_no = 16'd1;
    end else begin
      col_no = sat_up(col_no);
    end

    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
  endfunction

  // one random token with an optional separator
  function automatic void add_token();
    int pick;
    int n;
    string s;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      s = kw_words[$urandom_range(0, 4)];
      for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
    end else if (pick < 27) begin
      if ($urandom_range(0, 2) == 0) begin
        s = kw_words[$urandom_range(0, 4)];
        n = $urandom_range(0, 1) ? s.len() - 1 : s.len();
        for (int i = 0; i < n; i++) src_text.push_back(s[i]);
        if (n == s.len()) src_text.push_back(word_chars[$urandom_range(0, 62)]);
      end else begin
        src_text.push_back(word_chars[$urandom_range(0, 51)]);
        if ($urandom_range(0, 7) == 0) src_text[src_text.size()-1] = CH_USCORE;
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) src_text.push_back(word_chars[$urandom_range(0, 62)]);
      end
    end else if (pick < 42) begin
      if ($urandom_range(0, 2) == 0) src_text.push_back(CH_DASH);
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) src_text.push_back(8'($urandom_range("0", "9")));
    end else if (pick < 55) begin
      src_text.push_back(sym_chars[$urandom_range(0, sym_chars.len() - 1)]);
    end else if (pick < 67) begin
      src_text.push_back(CH_QUOTE);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          s = "";
          src_text.push_back(8'($urandom_range(32, 126)));
          if (src_text[src_text.size()-1] == CH_QUOTE ||
              src_text[src_text.size()-1] == CH_BSLASH) src_text[src_text.size()-1] = "k";
        end else if (pick < 78) begin
          src_text.push_back(8'($urandom_range(0, 1) ? $urandom_range(128, 255)
                                                      : $urandom_range(1, 31)));
        end else if (pick < 94) begin
          src_text.push_back(CH_BSLASH);
          src_text.push_back(esc_chars[$urandom_range(0, 6)]);
        end else begin
          src_text.push_back(CH_BSLASH);
          src_text.push_back(8'($urandom_range(1, 255)));
        end
      end
      if ($urandom_range(0, 19) != 0) src_text.push_back(CH_QUOTE);
    end else if (pick < 73) begin
      src_text.push_back(CH_DASH);
      src_text.push_back(CH_DASH);
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        src_text.push_back(8'($urandom_range(1, 255)));
        if (src_text[src_text.size()-1] == CH_LF) src_text[src_text.size()-1] = "c";
      end
      src_text.push_back(CH_LF);
    end else if (pick < 79) begin
      src_text.push_back(8'($urandom_range(1, 255)));
    end else if (pick < 81) begin
      src_text.push_back(CH_NUL);
    end else begin
      src_text.push_back(8'($urandom_range(0, 5) == 0 ? " " : $urandom_range(9, 13)));
    end
    pick = $urandom_range(0, 3);
    if (pick == 1) src_text.push_back(" ");
    else if (pick == 2) src_text.push_back(CH_LF);
  endfunction

  // drive one word on the src channel and queue its expected tokens once taken (given or predicted)
  task automatic feed_byte(input logic [7:0] b, input bit typed, input result_t want);
    if ($urandom_range(0, 99) < sender_idle) begin
      src_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < sender_idle) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_byte <= b;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    lex_byte(b);
    if (typed) expected_tokens.push_back(want);
    else foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n);
    sender_idle = idle;
    stall_pct = stall;
    src_text = {};
    while (src_text.size() < n) add_token();
    src_text.push_back(CH_NUL);
    foreach (src_text[i]) feed_byte(src_text[i], 1'b0, '0);
    drain();
  endtask

  function automatic void report(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected kind %0d byte %h line %0d col %0d len %0d last %0b",
               $realtime, what, want.kind, want.tbyte, want.line, want.column,
               want.length, want.last);
      $display("    got kind %0d byte %h line %0d col %0d len %0d last %0b",
               got.kind, got.tbyte, got.line, got.column, got.length, got.last);
    end
  endfunction

  always @(posedge clk) begin
    token_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : check_tokens
    result_t got;
    result_t want;
    if (!rst && token_valid && !token_stall) begin
      got.kind = tok_kind_t'(token_kind);
      got.tbyte = token_byte;
      got.line = token_line;
      got.column = token_column;
      got.length = token_length;
      got.last = last_of_run;
      if (expected_tokens.size() == 0) begin
        report("unexpected word", '0, got);
      end else begin
        want = expected_tokens.pop_front();
        if (got.kind !== want.kind || got.tbyte !== want.tbyte || got.line !== want.line ||
            got.column !== want.column || got.length !== want.length ||
            got.last !== want.last) report("token mismatch", want, got);
      end
    end
  end

  initial begin
    clear_lexer();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) feed_byte(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
    drain();

    run_phase(0, 0, 260);
    run_phase(76, 0, 260);
    run_phase(0, 76, 260);
    run_phase(28, 28, 260);
    run_phase(0, 0, 100);

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
